@@ rtl/hmd_pkg.sv @@
// ----------------------------------------------------------------------------
// hmd_pkg
// Shared sizes, queue entry type and code functions for the Hamming decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmd_pkg;

  localparam int CODE_BITS  = 31;
  localparam int CHECK_BITS = 5;
  localparam int DATA_BITS  = CODE_BITS - CHECK_BITS;
  localparam int COUNT_W    = 16;
  localparam int BYTE_W     = 8;

  // bit buffer in the back end: up to seven leftover bits plus one codeword's data bits
  localparam int BUF_W = DATA_BITS + BYTE_W - 1;
  localparam int CNT_W = $clog2(BUF_W + 1);

  // entries in the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic                 fixed;
    logic [COUNT_W-1:0]   count;
  } entry_t;

  // xor of the 1-based positions of every set bit
  function automatic logic [CHECK_BITS-1:0] syndrome_of(input logic [CODE_BITS-1:0] cw);
    logic [CHECK_BITS-1:0] syn;
    syn = '0;
    for (int pos = 1; pos <= CODE_BITS; pos++) begin
      if (cw[pos-1]) begin
        syn = syn ^ CHECK_BITS'(pos);
      end
    end
    return syn;
  endfunction

  // drop power-of-two positions, keep data bits in ascending order
  function automatic logic [DATA_BITS-1:0] data_of(input logic [CODE_BITS-1:0] cw);
    logic [DATA_BITS-1:0] data;
    int                   k;
    data = '0;
    k    = 0;
    for (int pos = 1; pos <= CODE_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        data[k] = cw[pos-1];
        k       = k + 1;
      end
    end
    return data;
  endfunction

endpackage

@@ rtl/hmd_front.sv @@
// ----------------------------------------------------------------------------
// hmd_front
// Accepts codewords, corrects single errors, counts corrections and queues
// the data bits with their status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [hmd_pkg::CODE_BITS-1:0]  codeword_i,
  input  logic                           q_full_i,
  output logic                           q_wr_o,
  output hmd_pkg::entry_t                q_entry_o
);

  logic [hmd_pkg::COUNT_W-1:0]    corrected_q, corrected_d;
  logic [hmd_pkg::CHECK_BITS-1:0] syn;
  logic [hmd_pkg::CODE_BITS-1:0]  fixed_cw;
  logic                           has_err;
  logic                           flip_ok;

  assign syn     = hmd_pkg::syndrome_of(codeword_i);
  assign has_err = (syn != '0);
  // a syndrome past the end of a shortened code flips nothing
  assign flip_ok = has_err && (32'(syn) <= 32'(hmd_pkg::CODE_BITS));

  always_comb begin
    fixed_cw = codeword_i;
    if (flip_ok) begin
      fixed_cw = codeword_i ^ (hmd_pkg::CODE_BITS'(1) << (syn - 1'b1));
    end
  end

  always_comb begin
    corrected_d = corrected_q;
    if (has_err && (corrected_q != '1)) begin
      corrected_d = corrected_q + 1'b1;
    end
  end

  assign q_wr_o          = push_i && !q_full_i;
  assign q_entry_o.data  = hmd_pkg::data_of(fixed_cw);
  assign q_entry_o.fixed = has_err;
  assign q_entry_o.count = corrected_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corrected_q <= '0;
    end else if (q_wr_o) begin
      corrected_q <= corrected_d;
    end
  end

endmodule

@@ rtl/hmd_fifo.sv @@
// ----------------------------------------------------------------------------
// hmd_fifo
// Short queue of decoded entries between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  hmd_pkg::entry_t wr_entry_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output hmd_pkg::entry_t rd_entry_o
);

  hmd_pkg::entry_t               mem_q [hmd_pkg::Q_DEPTH];
  logic [hmd_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hmd_pkg::Q_CNT_W-1:0]   cnt_q;

  assign full_o     = (cnt_q == hmd_pkg::Q_CNT_W'(hmd_pkg::Q_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  function automatic logic [hmd_pkg::Q_PTR_W-1:0] next_ptr(
    input logic [hmd_pkg::Q_PTR_W-1:0] p
  );
    logic [hmd_pkg::Q_PTR_W-1:0] n;
    n = (p == hmd_pkg::Q_PTR_W'(hmd_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/hmd_back.sv @@
// ----------------------------------------------------------------------------
// hmd_back
// Packs queued data bits into bytes and emits one byte per cycle through
// an output register, while that register is free or being popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  hmd_pkg::entry_t               q_entry_i,
  output logic                          q_rd_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [hmd_pkg::BYTE_W-1:0]    data_byte_o,
  output logic                          last_of_run_o,
  output logic                          error_corrected_o,
  output logic [hmd_pkg::COUNT_W-1:0]   errors_total_o
);

  logic [hmd_pkg::BUF_W-1:0]   buf_q, buf_d, rem_buf;
  logic [hmd_pkg::CNT_W-1:0]   bits_q, bits_d, rem_bits;
  logic                        cur_fixed_q;
  logic [hmd_pkg::COUNT_W-1:0] cur_count_q;
  logic                        out_valid_q;
  logic [hmd_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_last_q;
  logic                        out_fixed_q;
  logic [hmd_pkg::COUNT_W-1:0] out_count_q;
  logic                        slot_free;
  logic                        emit;
  logic                        load;

  assign slot_free = !out_valid_q || pop_i;
  assign emit      = slot_free && (bits_q >= hmd_pkg::CNT_W'(hmd_pkg::BYTE_W));

  // what is left once this cycle's byte is gone
  assign rem_buf  = emit ? (buf_q >> hmd_pkg::BYTE_W) : buf_q;
  assign rem_bits = emit ? (bits_q - hmd_pkg::CNT_W'(hmd_pkg::BYTE_W)) : bits_q;

  // next codeword joins as soon as less than one byte remains
  assign load   = q_valid_i && (rem_bits < hmd_pkg::CNT_W'(hmd_pkg::BYTE_W));
  assign q_rd_o = load;

  always_comb begin
    buf_d  = rem_buf;
    bits_d = rem_bits;
    if (load) begin
      buf_d  = rem_buf | (hmd_pkg::BUF_W'(q_entry_i.data) << rem_bits[2:0]);
      bits_d = rem_bits + hmd_pkg::CNT_W'(hmd_pkg::DATA_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      bits_q <= bits_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_fixed_q <= q_entry_i.fixed;
      cur_count_q <= q_entry_i.count;
    end
    if (emit) begin
      out_byte_q  <= buf_q[hmd_pkg::BYTE_W-1:0];
      // the codeword's last byte leaves under one byte behind
      out_last_q  <= (bits_q < hmd_pkg::CNT_W'(2 * hmd_pkg::BYTE_W));
      out_fixed_q <= cur_fixed_q;
      out_count_q <= cur_count_q;
    end
  end

  assign empty_o           = !out_valid_q;
  assign data_byte_o       = out_byte_q;
  assign last_of_run_o     = out_last_q;
  assign error_corrected_o = out_fixed_q;
  assign errors_total_o    = out_count_q;

endmodule

@@ rtl/hamming_31_26_decode_pack.sv @@
// A codeword's first byte passes the queue, the bit buffer and the output
// register before it can be popped. The back end emits one byte per cycle
// while its output register is free or popped; a codeword's 26 data bits fill
// 3 or 4 bytes. Reset clears the bit packer, the correction counter and the
// queue; the block accepts codewords right after reset, as the queue is empty.
// ----------------------------------------------------------------------------
// hamming_31_26_decode_pack
// Hamming (31,26) single error correcting decoder with byte packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hamming_31_26_decode_pack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [hmd_pkg::CODE_BITS-1:0] codeword_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [hmd_pkg::BYTE_W-1:0]    data_byte_o,
  output logic                          last_of_run_o,
  output logic                          error_corrected_o,
  output logic [hmd_pkg::COUNT_W-1:0]   errors_total_o
);

  logic            q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_valid;
  hmd_pkg::entry_t wr_entry;
  hmd_pkg::entry_t rd_entry;

  assign full = q_full;

  hmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .codeword_i (codeword_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_entry_o  (wr_entry)
  );

  hmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .valid_o    (q_valid),
    .rd_entry_o (rd_entry)
  );

  hmd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_entry_i         (rd_entry),
    .q_rd_o            (q_rd),
    .empty_o           (empty),
    .pop_i             (pop),
    .data_byte_o       (data_byte_o),
    .last_of_run_o     (last_of_run_o),
    .error_corrected_o (error_corrected_o),
    .errors_total_o    (errors_total_o)
  );

  a_no_read_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> q_valid)
    else $error("queue read with no entry");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_full)
    else $error("queue written while full");

  a_flag_implies_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_corrected_o) |-> (errors_total_o != '0))
    else $error("corrected flag with zero error count");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) ##1 !empty |-> (errors_total_o >= $past(errors_total_o)))
    else $error("error count went down");

endmodule

@@ dv/hamming_31_26_decode_pack_tb.sv @@
// ----------------------------------------------------------------------------
// hamming_31_26_decode_pack_tb
// Self-checking bench for the Hamming (31,26) decoder and byte packer. A
// behavioral predictor tracks the syndrome correction, the saturating error
// count and the bit packer, and each popped byte is compared in order.
// Covers directed codewords, random valid, single-error and noisy codewords,
// long output back pressure, a full drain pause and a steady burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hamming_31_26_decode_pack_tb;

  localparam int CODE_W  = hmd_pkg::CODE_BITS;
  localparam int SYN_W   = hmd_pkg::CHECK_BITS;
  localparam int BYTE_W  = hmd_pkg::BYTE_W;
  localparam int COUNT_W = hmd_pkg::COUNT_W;
  localparam int LIMIT   = 2_000_000;

  typedef enum int {
    CW_CLEAN,
    CW_SINGLE,
    CW_NOISE
  } cw_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               last_of_run;
    logic               error_corrected;
    logic [COUNT_W-1:0] errors_total;
  } byte_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [CODE_W-1:0] codeword_i;
  logic              empty;
  logic              pop;
  logic [BYTE_W-1:0] data_byte_o;
  logic              last_of_run_o;
  logic              error_corrected_o;
  logic [COUNT_W-1:0] errors_total_o;

  hamming_31_26_decode_pack dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .codeword_i       (codeword_i),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .last_of_run_o    (last_of_run_o),
    .error_corrected_o(error_corrected_o),
    .errors_total_o   (errors_total_o)
  );

  // predictor state
  logic [BYTE_W-1:0]  pack_acc   = '0;
  int                 pack_cnt   = 0;
  logic [COUNT_W-1:0] corr_count = '0;

  byte_result_t expected_bytes[$];
  int           mismatches    = 0;
  int           cycle_count   = 0;
  int           rx_hold_cycles = 0;
  int           rx_gap        = 0;
  bit           rx_steady     = 0;
  bit           tx_steady     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [SYN_W-1:0] calc_syndrome(input logic [CODE_W-1:0] cw);
    logic [SYN_W-1:0] syn;
    syn = '0;
    for (int pos = 1; pos <= CODE_W; pos++) begin
      if (cw[pos-1]) begin
        syn ^= SYN_W'(pos);
      end
    end
    return syn;
  endfunction

  // flip the bit at the syndrome position so that the syndrome comes out zero
  function automatic logic [CODE_W-1:0] make_valid(input logic [CODE_W-1:0] raw);
    logic [SYN_W-1:0]  syn;
    logic [CODE_W-1:0] cw;
    cw  = raw;
    syn = calc_syndrome(cw);
    if (syn != '0) begin
      cw[syn-1] = ~cw[syn-1];
    end
    return cw;
  endfunction

  function automatic logic [CODE_W-1:0] random_codeword(input cw_kind_e kind);
    logic [CODE_W-1:0] cw;
    cw = CODE_W'($urandom);
    case (kind)
      CW_CLEAN: begin
        cw = make_valid(cw);
      end
      CW_SINGLE: begin
        cw = make_valid(cw);
        cw[$urandom_range(0, CODE_W - 1)] ^= 1'b1;
      end
      default: begin
      end
    endcase
    return cw;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // correct, strip parity positions and pack; queue every byte completed
  function automatic void predict_decode(input logic [CODE_W-1:0] cw_in);
    logic [CODE_W-1:0] cw;
    logic [SYN_W-1:0]  syn;
    logic              fixed;
    byte_result_t      res_buf[4];
    int                n;
    cw    = cw_in;
    syn   = calc_syndrome(cw);
    fixed = (syn != '0);
    n     = 0;
    if (fixed) begin
      if (int'(syn) <= CODE_W) begin
        cw[syn-1] = ~cw[syn-1];
      end
      if (corr_count != '1) begin
        corr_count++;
      end
    end
    for (int pos = 1; pos <= CODE_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        pack_acc[pack_cnt] = cw[pos-1];
        pack_cnt++;
        if (pack_cnt == BYTE_W) begin
          res_buf[n].data_byte       = pack_acc;
          res_buf[n].last_of_run     = 1'b0;
          res_buf[n].error_corrected = fixed;
          res_buf[n].errors_total    = corr_count;
          n++;
          pack_acc = '0;
          pack_cnt = 0;
        end
      end
    end
    if (n > 0) begin
      res_buf[n-1].last_of_run = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      expected_bytes.push_back(res_buf[k]);
    end
  endfunction

  // called right after a rising edge; leaves push high on return
  task automatic send_codeword(input logic [CODE_W-1:0] cw);
    codeword_i <= cw;
    push       <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (full);
    predict_decode(cw);
  endtask

  task automatic sender_idle(input int cycles);
    if (cycles > 0) begin
      push       <= 1'b0;
      codeword_i <= CODE_W'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic sender_gap();
    if (!tx_steady && $urandom_range(0, 99) < 35) begin
      sender_idle(pick_gap());
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // receiver: checks each popped byte, then decides next pop
  always @(posedge clk_i) begin : receiver
    byte_result_t exp_byte;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("byte 0x%h popped with nothing expected", data_byte_o);
          mismatches++;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (data_byte_o !== exp_byte.data_byte) begin
            $error("data_byte exp 0x%h got 0x%h", exp_byte.data_byte, data_byte_o);
            mismatches++;
          end
          if (last_of_run_o !== exp_byte.last_of_run) begin
            $error("last_of_run exp %b got %b", exp_byte.last_of_run, last_of_run_o);
            mismatches++;
          end
          if (error_corrected_o !== exp_byte.error_corrected) begin
            $error("error_corrected exp %b got %b", exp_byte.error_corrected,
                   error_corrected_o);
            mismatches++;
          end
          if (errors_total_o !== exp_byte.errors_total) begin
            $error("errors_total exp %0d got %0d", exp_byte.errors_total,
                   errors_total_o);
            mismatches++;
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_gap > 0) begin
        pop <= 1'b0;
        rx_gap--;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        pop    <= 1'b0;
        rx_gap = pick_gap() - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    logic [CODE_W-1:0] ones;
    ones = '1;
    send_codeword('0);
    send_codeword(ones);
    // single errors on each parity position
    send_codeword(CODE_W'(1) << 0);
    send_codeword(CODE_W'(1) << 1);
    send_codeword(CODE_W'(1) << 3);
    sender_gap();
    send_codeword(CODE_W'(1) << 7);
    send_codeword(CODE_W'(1) << 15);
    // single errors on data positions, including syndrome 31
    send_codeword(CODE_W'(1) << 2);
    send_codeword(CODE_W'(1) << (CODE_W - 1));
    send_codeword(ones ^ (CODE_W'(1) << (CODE_W - 1)));
    sender_gap();
    // double error miscorrects into a third bit
    send_codeword(CODE_W'(3));
    send_codeword(make_valid(CODE_W'(32'h5555_5555)));
    send_codeword(make_valid(CODE_W'(32'h2AAA_AAAA)));
    send_codeword(ones ^ (CODE_W'(1) << 0));
    sender_idle(1);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int       pick;
    cw_kind_e kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 35) ? CW_CLEAN : (pick < 75) ? CW_SINGLE : CW_NOISE;
      // a burst with no idling on either side
      tx_steady = (i >= count / 4) && (i < count / 4 + 20);
      rx_steady = tx_steady;
      send_codeword(random_codeword(kind));
      // sender waits out every outstanding byte once mid-run
      if (i == count / 2) begin
        wait_drained();
      end
      sender_gap();
    end
    tx_steady = 0;
    rx_steady = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 250;
    for (int i = 0; i < 12; i++) begin
      send_codeword(random_codeword(($urandom_range(0, 1) != 0) ? CW_SINGLE : CW_CLEAN));
    end
    wait_drained();
  endtask

  task automatic test_steady_burst();
    tx_steady = 1;
    rx_steady = 1;
    for (int i = 0; i < 4; i++) begin
      send_codeword(random_codeword(CW_SINGLE));
    end
    send_codeword(random_codeword(CW_CLEAN));
    send_codeword(random_codeword(CW_NOISE));
    tx_steady = 0;
    rx_steady = 0;
    wait_drained();
  endtask

  initial begin
    rst_ni     = 1'b0;
    push       = 1'b0;
    codeword_i = '0;
    pop        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(128);
    test_backpressure();
    test_steady_burst();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
